// ----- hdl/i3sb_pkg.sv -----
// Shared constants, types and codes of the 3x3 smoothing filter.
package i3sb_pkg;

  localparam int unsigned PIX_W      = 16;
  localparam int unsigned DIM_W      = 6;
  localparam int unsigned MAX_WIDTH  = 63;
  // A frame's flush returns width+1 words and at most 63 may follow one pixel.
  localparam int unsigned LINE_LEN   = (MAX_WIDTH < 62) ? MAX_WIDTH : 62;
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;

  localparam int unsigned SUM4_W      = PIX_W + 2;
  localparam int unsigned SUM_W       = PIX_W + 4;
  localparam int unsigned U_W         = SUM_W;
  localparam int unsigned Q_W         = PIX_W + 1;
  localparam int unsigned RECIP_SHIFT = 22;
  localparam int unsigned RECIP_W     = 19;
  localparam int unsigned RECIP       = ((2 ** RECIP_SHIFT) + 8) / 9;
  localparam int unsigned PROD_W      = U_W + RECIP_W;
  localparam int unsigned BLUR_SHIFT  = 4;
  localparam int unsigned HALF_MEAN   = 4;
  localparam int unsigned HALF_BLUR   = 8;

  typedef logic signed [PIX_W-1:0]  pix_t;
  typedef logic signed [SUM4_W-1:0] sum4_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic [DIM_W-1:0]         dim_t;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_MODE   = 2'd2
  } reg_idx_e;

  typedef enum logic {
    MODE_MEAN = 1'b0,
    MODE_BLUR = 1'b1
  } mode_e;

  typedef enum logic {
    ST_STREAM = 1'b0,
    ST_FLUSH  = 1'b1
  } state_e;

  // Per-shift control travelling with the window.
  typedef struct packed {
    logic  emit;
    logic  border;
    logic  last;
    mode_e mode;
  } tag_t;

  typedef struct packed {
    pix_t pix;
    logic last;
  } res_t;

endpackage

// ----- hdl/i3sb_line_cell.sv -----
// One stage of the variable-length line delay.
module i3sb_line_cell (
  input  logic          clk_i,
  input  logic          shift_i,
  input  logic          entry_i,
  input  i3sb_pkg::pix_t din_i,
  input  i3sb_pkg::pix_t near_i,
  output i3sb_pkg::pix_t q_o
);
  import i3sb_pkg::*;

  pix_t pix_q;

  // The entry cell takes the new pixel, the others take their upper neighbor.
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      pix_q <= entry_i ? din_i : near_i;
    end
  end

  assign q_o = pix_q;

endmodule

// ----- hdl/i3sb_line_delay.sv -----
// Line delay of exactly width pixels built from a row of cells.
module i3sb_line_delay (
  input  logic           clk_i,
  input  logic           shift_i,
  input  i3sb_pkg::dim_t width_i,
  input  i3sb_pkg::pix_t din_i,
  output i3sb_pkg::pix_t dout_o
);
  import i3sb_pkg::*;

  pix_t link [LINE_LEN+1];

  assign link[LINE_LEN] = din_i;

  for (genvar i = 0; i < LINE_LEN; i++) begin : g_cell
    logic entry;
    assign entry = (width_i == DIM_W'(i + 1));
    i3sb_line_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (shift_i),
      .entry_i (entry),
      .din_i   (din_i),
      .near_i  (link[i+1]),
      .q_o     (link[i])
    );
  end

  // Oldest pixel sits in cell 0.
  assign dout_o = link[0];

endmodule

// ----- hdl/i3sb_kernel.sv -----
// 3x3 window registers and the sum, round and divide pipeline.
module i3sb_kernel (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           adv_i,
  input  logic           shift_i,
  input  i3sb_pkg::pix_t bot_i,
  input  i3sb_pkg::pix_t mid_i,
  input  i3sb_pkg::pix_t top_i,
  input  i3sb_pkg::tag_t tag_i,
  output logic           valid_o,
  output i3sb_pkg::res_t res_o
);
  import i3sb_pkg::*;

  // window: index 0 is the newest column
  pix_t bot_q [3];
  pix_t mid_q [3];
  pix_t top_q [3];
  tag_t w_tag_q;
  logic w_valid_q;

  sum4_t a_corner_q, a_edge_q;
  pix_t  a_mid_q;
  tag_t  a_tag_q;
  logic  a_valid_q;

  sum_t  b_total_q;
  pix_t  b_center_q;
  tag_t  b_tag_q;
  logic  b_valid_q;

  logic [U_W-1:0] c_u_q;
  logic           c_neg_q;
  pix_t           c_center_q;
  tag_t           c_tag_q;
  logic           c_valid_q;

  logic [Q_W-1:0] d_q;
  logic           d_neg_q;
  pix_t           d_center_q;
  tag_t           d_tag_q;
  logic           d_valid_q;

  sum4_t                 corner_sum, edge_sum;
  sum_t                  edge_term, mid_term, total;
  logic signed [SUM_W:0] half, rnd;
  logic [PROD_W-1:0]     prod;
  logic [Q_W-1:0]        quot;
  logic signed [Q_W-1:0] val;

  always_comb begin
    corner_sum = sum4_t'(top_q[0]) + sum4_t'(top_q[2]) + sum4_t'(bot_q[0]) + sum4_t'(bot_q[2]);
    edge_sum   = sum4_t'(top_q[1]) + sum4_t'(bot_q[1]) + sum4_t'(mid_q[0]) + sum4_t'(mid_q[2]);

    edge_term = (a_tag_q.mode == MODE_BLUR) ? (sum_t'(a_edge_q) <<< 1) : sum_t'(a_edge_q);
    mid_term  = (a_tag_q.mode == MODE_BLUR) ? (sum_t'(a_mid_q) <<< 2) : sum_t'(a_mid_q);
    total     = sum_t'(a_corner_q) + edge_term + mid_term;

    // magnitude plus half the divisor: rounds to nearest, ties away from zero
    half = (b_tag_q.mode == MODE_BLUR) ? (SUM_W+1)'(HALF_BLUR) : (SUM_W+1)'(HALF_MEAN);
    rnd  = b_total_q[SUM_W-1] ? (half - (SUM_W+1)'(b_total_q))
                              : ((SUM_W+1)'(b_total_q) + half);

    // divide by 9 as a reciprocal multiply, by 16 as a shift
    prod = PROD_W'(c_u_q) * PROD_W'(RECIP);
    quot = (c_tag_q.mode == MODE_BLUR) ? Q_W'(c_u_q >> BLUR_SHIFT)
                                       : prod[RECIP_SHIFT +: Q_W];

    val = d_neg_q ? -$signed(d_q) : $signed(d_q);
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      bot_q[0] <= bot_i;
      mid_q[0] <= mid_i;
      top_q[0] <= top_i;
      for (int i = 1; i < 3; i++) begin
        bot_q[i] <= bot_q[i-1];
        mid_q[i] <= mid_q[i-1];
        top_q[i] <= top_q[i-1];
      end
      w_tag_q <= tag_i;
    end
    if (adv_i) begin
      a_corner_q <= corner_sum;
      a_edge_q   <= edge_sum;
      a_mid_q    <= mid_q[1];
      a_tag_q    <= w_tag_q;

      b_total_q  <= total;
      b_center_q <= a_mid_q;
      b_tag_q    <= a_tag_q;

      c_u_q      <= rnd[U_W-1:0];
      c_neg_q    <= b_total_q[SUM_W-1];
      c_center_q <= b_center_q;
      c_tag_q    <= b_tag_q;

      d_q        <= quot;
      d_neg_q    <= c_neg_q;
      d_center_q <= c_center_q;
      d_tag_q    <= c_tag_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_valid_q <= 1'b0;
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
    end else if (adv_i) begin
      w_valid_q <= shift_i && tag_i.emit;
      a_valid_q <= w_valid_q;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
      d_valid_q <= c_valid_q;
    end
  end

  assign valid_o    = d_valid_q;
  assign res_o.pix  = d_tag_q.border ? d_center_q : val[PIX_W-1:0];
  assign res_o.last = d_tag_q.last;

endmodule

// ----- hdl/image_3x3_smooth_blur.sv -----
// Top level: raster pixel stream through a 3x3 mean or 1-2-1 blur filter.
//
//  port group  dir  word                    accepted when
//  s_axis      in   pixel_in (Q8.8)         s_axis_tvalid & s_axis_tready
//  m_axis      out  pixel_out, tlast=last   m_axis_tvalid & m_axis_tready
//  apb         in   width/height/mode regs  psel & penable & pwrite (pready=1)
//
// One pixel per clock while the skid word is empty and no flush runs. Output k leaves
// once pixel k+width+1 is in, then five pipeline stages (window, two adds, round,
// multiply) before the output register. After the final pixel of a frame the input
// is held off while the two line delays drain the last row; that flush ends with tlast.
// A stalled output fills the skid word, which freezes the whole pipeline.
// Reset clears control only; no memory clearing pass is needed.
module image_3x3_smooth_blur (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [i3sb_pkg::PIX_W-1:0]            s_axis_tdata,  // [15:0] pixel_in
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [i3sb_pkg::PIX_W-1:0]            m_axis_tdata,  // [15:0] pixel_out
  output logic                                  m_axis_tlast,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [i3sb_pkg::CFG_ADDR_W-1:0]       paddr,
  input  logic [i3sb_pkg::CFG_DATA_W-1:0]       pwdata,
  output logic [i3sb_pkg::CFG_DATA_W-1:0]       prdata,
  output logic                                  pready
);
  import i3sb_pkg::*;

  // configuration
  dim_t     width_q, height_q;
  mode_e    mode_q;
  reg_idx_e reg_idx;

  // frame control
  state_e state_q, state_d;
  dim_t   cnt_q, cnt_d;
  dim_t   in_col_q, in_col_d, in_row_q, in_row_d;
  dim_t   cur_w_q, cur_w_d, cur_h_q, cur_h_d;
  mode_e  cur_mode_q, cur_mode_d;
  dim_t   lead_q, lead_d;
  dim_t   out_col_q, out_col_d, out_row_q, out_row_d;

  dim_t  eff_w, eff_h, w_use, h_use, lead_base;
  mode_e mode_use;
  logic  frame_start, in_final, in_acc, flush_shift, shift, lead_full, emit, adv;
  tag_t  tag;

  pix_t pix_in, l1_out, l2_out;

  logic k_valid, push;
  res_t k_res;
  logic out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  res_t out_q, out_d, skid_q, skid_d;

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[CFG_ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= dim_t'(63);
      height_q <= dim_t'(63);
      mode_q   <= MODE_MEAN;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_WIDTH:  width_q  <= pwdata[DIM_W-1:0];
        REG_HEIGHT: height_q <= pwdata[DIM_W-1:0];
        REG_MODE:   mode_q   <= mode_e'(pwdata[0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WIDTH:  prdata = CFG_DATA_W'(width_q);
      REG_HEIGHT: prdata = CFG_DATA_W'(height_q);
      REG_MODE:   prdata = CFG_DATA_W'(mode_q);
      default:    prdata = '0;
    endcase
  end

  // ---------------- frame control ----------------
  assign adv = !skid_valid_q;

  always_comb begin
    if (width_q == '0) begin
      eff_w = dim_t'(1);
    end else if (width_q > dim_t'(LINE_LEN)) begin
      eff_w = dim_t'(LINE_LEN);
    end else begin
      eff_w = width_q;
    end
    eff_h = (height_q == '0) ? dim_t'(1) : height_q;
  end

  // frame geometry is latched on the first pixel
  assign frame_start = (state_q == ST_STREAM) && (in_col_q == '0) && (in_row_q == '0);
  assign w_use       = frame_start ? eff_w : cur_w_q;
  assign h_use       = frame_start ? eff_h : cur_h_q;
  assign mode_use    = frame_start ? mode_q : cur_mode_q;
  assign in_final    = (in_col_q == w_use - dim_t'(1)) && (in_row_q == h_use - dim_t'(1));

  assign s_axis_tready = adv && (state_q == ST_STREAM);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign flush_shift   = (state_q == ST_FLUSH) && adv;
  assign shift         = in_acc || flush_shift;

  // a word leaves once width+1 pixels of the frame have gone by
  assign lead_base = (in_acc && frame_start) ? '0 : lead_q;
  assign lead_full = (lead_base == w_use + dim_t'(1));
  assign emit      = shift && lead_full;

  assign tag.emit   = emit;
  assign tag.border = (out_row_q == '0) || (out_col_q == '0) ||
                      (out_row_q == cur_h_q - dim_t'(1)) || (out_col_q == cur_w_q - dim_t'(1));
  assign tag.last   = (out_row_q == cur_h_q - dim_t'(1)) && (out_col_q == cur_w_q - dim_t'(1));
  assign tag.mode   = cur_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_STREAM;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_STREAM: begin
        if (in_acc && in_final) begin
          state_d = ST_FLUSH;
          cnt_d   = w_use + dim_t'(1);
        end
      end
      ST_FLUSH: begin
        if (adv) begin
          cnt_d = cnt_q - dim_t'(1);
          if (cnt_q == dim_t'(1)) begin
            state_d = ST_STREAM;
          end
        end
      end
      default: state_d = ST_STREAM;
    endcase
  end

  always_comb begin
    in_col_d   = in_col_q;
    in_row_d   = in_row_q;
    cur_w_d    = cur_w_q;
    cur_h_d    = cur_h_q;
    cur_mode_d = cur_mode_q;
    lead_d     = shift ? (lead_full ? lead_base : lead_base + dim_t'(1)) : lead_q;
    out_col_d  = out_col_q;
    out_row_d  = out_row_q;

    if (in_acc) begin
      if (frame_start) begin
        cur_w_d    = w_use;
        cur_h_d    = h_use;
        cur_mode_d = mode_use;
      end
      if (in_final) begin
        in_col_d = '0;
        in_row_d = '0;
      end else if (in_col_q == w_use - dim_t'(1)) begin
        in_col_d = '0;
        in_row_d = in_row_q + dim_t'(1);
      end else begin
        in_col_d = in_col_q + dim_t'(1);
      end
    end

    if (in_acc && frame_start) begin
      out_col_d = '0;
      out_row_d = '0;
    end else if (emit) begin
      if (out_col_q == cur_w_q - dim_t'(1)) begin
        out_col_d = '0;
        out_row_d = out_row_q + dim_t'(1);
      end else begin
        out_col_d = out_col_q + dim_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q   <= '0;
      in_row_q   <= '0;
      cur_w_q    <= dim_t'(1);
      cur_h_q    <= dim_t'(1);
      cur_mode_q <= MODE_MEAN;
      lead_q     <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
    end else begin
      in_col_q   <= in_col_d;
      in_row_q   <= in_row_d;
      cur_w_q    <= cur_w_d;
      cur_h_q    <= cur_h_d;
      cur_mode_q <= cur_mode_d;
      lead_q     <= lead_d;
      out_col_q  <= out_col_d;
      out_row_q  <= out_row_d;
    end
  end

  // ---------------- datapath ----------------
  assign pix_in = $signed(s_axis_tdata);

  i3sb_line_delay u_line1 (
    .clk_i   (clk_i),
    .shift_i (shift),
    .width_i (w_use),
    .din_i   (pix_in),
    .dout_o  (l1_out)
  );

  i3sb_line_delay u_line2 (
    .clk_i   (clk_i),
    .shift_i (shift),
    .width_i (w_use),
    .din_i   (l1_out),
    .dout_o  (l2_out)
  );

  i3sb_kernel u_kernel (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .shift_i (shift),
    .bot_i   (pix_in),
    .mid_i   (l1_out),
    .top_i   (l2_out),
    .tag_i   (tag),
    .valid_o (k_valid),
    .res_o   (k_res)
  );

  // ---------------- output register and skid word ----------------
  assign push = adv && k_valid;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (m_axis_tready) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_q || m_axis_tready) begin
        out_d       = k_res;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = k_res;
        skid_valid_d = 1'b1;
      end
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q.pix;
  assign m_axis_tlast  = out_q.last;

  // ---------------- assertions ----------------
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid word held while output register empty");

  a_final_starts_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_final) |=> (state_q == ST_FLUSH))
    else $error("final pixel did not start the flush");

  a_flush_count_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FLUSH) |-> (cnt_q != '0))
    else $error("flush running with zero count");

  a_last_ends_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && tag.last) |-> (flush_shift && (cnt_q == dim_t'(1))))
    else $error("frame end word not on the final flush shift");

endmodule
